// File: rtl/srsg_pkg.sv
package srsg_pkg;

    // Command codes carried in the mode field of an input item.
    typedef enum logic [2:0] {
        MODE_TICK       = 3'd0,
        MODE_SET_ACCEL  = 3'd1,
        MODE_SET_MAX    = 3'd2,
        MODE_SET_TARGET = 3'd3,
        MODE_RESET      = 3'd4
    } mode_t;

    // Configuration register indexes.
    typedef enum logic {
        REG_SPEED_RES  = 1'b0,
        REG_INVERT_DIR = 1'b1
    } cfg_reg_t;

    localparam int MODE_W  = 3;
    localparam int DATA_W  = 32;
    localparam int RES_W   = 16;
    localparam int PHASE_W = 34;
    localparam int THR_W   = 2 * RES_W;

    localparam logic [RES_W-1:0] RES_RESET = 16'd20000;
    localparam logic [THR_W-1:0] THR_RESET = 32'd400000000;

endpackage

// File: rtl/stepper_ramp_step_generator.sv
// Stepper step and direction generator: a phase accumulator with an acceleration ramp.
// An accepted item waits in the input register and moves into the result register when that one advances.
// Throughput: one item per cycle while not stalled; each command is evaluated in one pass between the two.
// A result register that is held by out_stall stalls the input only when both stages are full.
// rst_n (asynchronous, active low) clears all motion state and loads the register defaults.
module stepper_ramp_step_generator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write port.
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [srsg_pkg::RES_W-1:0]           cfg_data,
    // Command channel.
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [srsg_pkg::MODE_W-1:0]          mode,
    input  logic signed [srsg_pkg::DATA_W-1:0]   value,
    // Result channel.
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 step_pulse,
    output logic                                 direction,
    output logic signed [srsg_pkg::DATA_W-1:0]   position,
    output logic signed [srsg_pkg::DATA_W-1:0]   speed
);

    localparam int DW = srsg_pkg::DATA_W;
    localparam int RW = srsg_pkg::RES_W;
    localparam int PW = srsg_pkg::PHASE_W;
    localparam int TW = srsg_pkg::THR_W;

    // Saturate a wide signed value to the 32-bit signed range.
    function automatic logic signed [DW-1:0] sat32(input logic signed [49:0] v);
        logic signed [49:0] hi;
        logic signed [49:0] lo;
        hi = 50'sd2147483647;
        lo = -50'sd2147483648;
        if (v > hi)
            return DW'(hi);
        else if (v < lo)
            return DW'(lo);
        else
            return DW'(v);
    endfunction

    // Configuration registers and the derived step threshold.
    logic [RW-1:0] res_reg;
    logic          invert_reg;
    logic [TW-1:0] thr_reg;
    logic [RW-1:0] res_eff;

    // Input stage.
    logic                          in_full_reg;
    logic [srsg_pkg::MODE_W-1:0]   mode_reg;
    logic signed [DW-1:0]          value_reg;

    // Motion state.
    logic signed [DW-1:0] position_reg, position_next;
    logic signed [PW-1:0] phase_reg, phase_next;
    logic signed [DW-1:0] speed_reg, speed_next;
    logic signed [DW-1:0] accel_reg, accel_next;
    logic signed [DW-1:0] target_reg, target_next;
    logic signed [DW-1:0] max_reg, max_next;
    logic                 speed_mode_reg, speed_mode_next;
    logic                 dir_reg, dir_next;
    logic                 step_next;

    // Result stage.
    logic                 out_full_reg;
    logic                 out_step_reg;
    logic                 out_dir_reg;
    logic signed [DW-1:0] out_pos_reg;
    logic signed [DW-1:0] out_speed_reg;

    // Handshake control.
    logic advance;
    logic take_in;

    // Tick and command intermediates.
    logic signed [35:0] spd_w;
    logic signed [35:0] acc_w;
    logic signed [35:0] trg_w;
    logic signed [35:0] max_w;
    logic signed [35:0] diff_w;
    logic signed [DW-1:0] acc_sat;
    logic signed [DW-1:0] spd_sat;
    logic signed [36:0] ph_w;
    logic signed [36:0] thr_w;
    logic signed [36:0] ph_hi;
    logic signed [36:0] ph_lo;
    logic signed [32:0] arg_w;
    logic signed [32:0] res_w;
    logic signed [49:0] prod_w;

    assign res_eff = (res_reg == '0) ? RW'(1) : res_reg;

    // The result register moves when it is empty or being taken.
    assign advance  = !out_full_reg || !out_stall;
    assign in_stall = in_full_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    assign out_valid  = out_full_reg;
    assign step_pulse = out_step_reg;
    assign direction  = out_dir_reg;
    assign position   = out_pos_reg;
    assign speed      = out_speed_reg;

    // Configuration writes; the threshold is registered from the resolution and follows it in the following cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg    <= srsg_pkg::RES_RESET;
            invert_reg <= 1'b0;
            thr_reg    <= srsg_pkg::THR_RESET;
        end
        else
        begin
            if (cfg_we && cfg_index == srsg_pkg::REG_SPEED_RES)
                res_reg <= cfg_data;
            if (cfg_we && cfg_index == srsg_pkg::REG_INVERT_DIR)
                invert_reg <= cfg_data[0];
            thr_reg <= TW'(res_eff) * TW'(res_eff);
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else if (take_in)
            in_full_reg <= 1'b1;
        else if (advance)
            in_full_reg <= 1'b0;
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            mode_reg  <= mode;
            value_reg <= value;
        end
    end

    // Evaluate the command in the input register against the current state.
    always_comb
    begin
        position_next   = position_reg;
        phase_next      = phase_reg;
        speed_next      = speed_reg;
        accel_next      = accel_reg;
        target_next     = target_reg;
        max_next        = max_reg;
        speed_mode_next = speed_mode_reg;
        dir_next        = dir_reg;
        step_next       = 1'b0;

        spd_w   = 36'(speed_reg);
        acc_w   = 36'(accel_reg);
        trg_w   = 36'(target_reg);
        max_w   = 36'(max_reg);
        diff_w  = '0;
        acc_sat = accel_reg;
        spd_sat = speed_reg;
        ph_w    = '0;
        thr_w   = $signed({5'b0, thr_reg});
        ph_hi   = 37'(35'sh3_FFFF_FFFF >>> 1);
        ph_lo   = -ph_hi - 37'sd1;

        // Argument of the speed commands, capped at the resolution.
        res_w = $signed({17'b0, res_eff});
        arg_w = 33'(value_reg);
        if (arg_w > res_w)
            arg_w = res_w;
        if (mode_reg == srsg_pkg::MODE_SET_TARGET && arg_w < -res_w)
            arg_w = -res_w;
        prod_w = 50'(arg_w) * 50'(res_w);

        case (srsg_pkg::mode_t'(mode_reg))
            srsg_pkg::MODE_TICK:
            begin
                // Speed mode steers the acceleration towards the target.
                if (speed_mode_reg)
                begin
                    if (spd_w >= trg_w)
                    begin
                        if (acc_w > 0)
                            acc_w = -acc_w;
                        diff_w = trg_w - spd_w - acc_w;
                        if (diff_w > 0)
                            spd_w = trg_w - acc_w;
                    end
                    else
                    begin
                        if (acc_w < 0)
                            acc_w = -acc_w;
                        diff_w = trg_w - spd_w - acc_w;
                        if (diff_w < 0)
                            spd_w = trg_w - acc_w;
                    end
                    acc_sat    = sat32(50'(acc_w));
                    accel_next = acc_sat;
                    acc_w      = 36'(acc_sat);
                end

                spd_w = spd_w + acc_w;

                // Acceleration mode clamps to plus or minus the maximum.
                if (!speed_mode_reg)
                begin
                    if (spd_w > max_w)
                        spd_w = max_w;
                    if (spd_w < -max_w)
                        spd_w = -max_w;
                end
                spd_sat    = sat32(50'(spd_w));
                speed_next = spd_sat;

                // Phase accumulation and step detection.
                ph_w = 37'(phase_reg) + 37'(spd_sat);
                if (ph_w >= thr_w)
                begin
                    ph_w          = ph_w - thr_w;
                    position_next = position_reg + DW'(1);
                    dir_next      = !invert_reg;
                    step_next     = 1'b1;
                end
                else if (ph_w <= -thr_w)
                begin
                    ph_w          = ph_w + thr_w;
                    position_next = position_reg - DW'(1);
                    dir_next      = invert_reg;
                    step_next     = 1'b1;
                end
                if (ph_w > ph_hi)
                    ph_w = ph_hi;
                if (ph_w < ph_lo)
                    ph_w = ph_lo;
                phase_next = PW'(ph_w);
            end
            srsg_pkg::MODE_SET_ACCEL:
                accel_next = value_reg;
            srsg_pkg::MODE_SET_MAX:
            begin
                max_next        = sat32(prod_w);
                speed_mode_next = 1'b0;
            end
            srsg_pkg::MODE_SET_TARGET:
            begin
                target_next     = sat32(prod_w);
                speed_mode_next = 1'b1;
            end
            srsg_pkg::MODE_RESET:
            begin
                phase_next    = '0;
                speed_next    = '0;
                position_next = '0;
                if (speed_mode_reg)
                    target_next = '0;
                else
                    accel_next = '0;
            end
            default:
            begin
                step_next = 1'b0;
            end
        endcase
    end

    // State update when the item moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            phase_reg      <= '0;
            speed_reg      <= '0;
            accel_reg      <= '0;
            target_reg     <= '0;
            max_reg        <= '0;
            speed_mode_reg <= 1'b0;
            dir_reg        <= 1'b0;
        end
        else if (advance && in_full_reg)
        begin
            position_reg   <= position_next;
            phase_reg      <= phase_next;
            speed_reg      <= speed_next;
            accel_reg      <= accel_next;
            target_reg     <= target_next;
            max_reg        <= max_next;
            speed_mode_reg <= speed_mode_next;
            dir_reg        <= dir_next;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_full_reg <= 1'b0;
        else if (advance)
            out_full_reg <= in_full_reg;
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance && in_full_reg)
        begin
            out_step_reg  <= step_next;
            out_dir_reg   <= dir_next;
            out_pos_reg   <= position_next;
            out_speed_reg <= speed_next;
        end
    end

endmodule
